// ===== rtl/ias_pkg.sv =====
`default_nettype none
package ias_pkg;

    localparam int SLOT_W  = 3;
    localparam int STATE_W = 2;
    localparam int PRIO_W  = 8;

    localparam logic [STATE_W-1:0] PS_UNUSED  = 2'd0;
    localparam logic [STATE_W-1:0] PS_READY   = 2'd1;
    localparam logic [STATE_W-1:0] PS_RUNNING = 2'd2;
    localparam logic [STATE_W-1:0] PS_BLOCKED = 2'd3;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_SCHED = 1'b1;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_SCAN,
        CS_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic write;
        logic load;
        logic scan;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/ias_item_if.sv =====
`default_nettype none
interface ias_item_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [ias_pkg::SLOT_W-1:0]  slot;
    logic [ias_pkg::STATE_W-1:0] slot_state;
    logic [ias_pkg::PRIO_W-1:0]  slot_priority;
    logic                        clear_age;
    logic [ias_pkg::SLOT_W-1:0]  current;

    modport source (
        output valid, kind, slot, slot_state, slot_priority, clear_age, current,
        input  ready
    );
    modport sink (
        input  valid, kind, slot, slot_state, slot_priority, clear_age, current,
        output ready
    );
endinterface

interface ias_result_if;
    logic                       valid;
    logic                       ready;
    logic [ias_pkg::SLOT_W-1:0] next_slot;

    modport source (output valid, next_slot, input ready);
    modport sink (input valid, next_slot, output ready);
endinterface
`default_nettype wire

// ===== rtl/ias_ctrl.sv =====
`default_nettype none
module ias_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    input  wire logic               item_kind,
    output logic                    item_ready,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output ias_pkg::ctrl_cmd_t      cmd,
    input  wire ias_pkg::dp_status_t status
);

    ias_pkg::ctrl_state_t state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 can_finish;

    assign can_finish = !out_valid_reg || result_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ias_pkg::CS_IDLE:
            begin
                if (item_valid && item_kind == ias_pkg::KIND_SCHED)
                begin
                    state_next = ias_pkg::CS_SCAN;
                end
            end
            ias_pkg::CS_SCAN:
            begin
                if (status.last)
                begin
                    state_next = ias_pkg::CS_FINISH;
                end
            end
            ias_pkg::CS_FINISH:
            begin
                if (can_finish)
                begin
                    state_next = ias_pkg::CS_IDLE;
                end
            end
            default:
            begin
                state_next = ias_pkg::CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ias_pkg::CS_IDLE:
            begin
                item_ready = 1'b1;
                cmd.write  = item_valid && item_kind == ias_pkg::KIND_WRITE;
                cmd.load   = item_valid && item_kind == ias_pkg::KIND_SCHED;
            end
            ias_pkg::CS_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ias_pkg::CS_FINISH:
            begin
                cmd.finish = can_finish;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign result_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ias_pkg::CS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ias_datapath.sv =====
`default_nettype none
module ias_datapath #(
    parameter int SLOT_COUNT = 8,
    parameter int AGE_BITS   = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ias_pkg::ctrl_cmd_t            cmd,
    output ias_pkg::dp_status_t                status,
    input  wire logic [ias_pkg::SLOT_W-1:0]    slot,
    input  wire logic [ias_pkg::STATE_W-1:0]   slot_state,
    input  wire logic [ias_pkg::PRIO_W-1:0]    slot_priority,
    input  wire logic                          clear_age,
    input  wire logic [ias_pkg::SLOT_W-1:0]    current,
    output logic [ias_pkg::SLOT_W-1:0]         next_slot
);

    localparam int IDX_W = $clog2(SLOT_COUNT);

    logic [ias_pkg::STATE_W-1:0] state_reg [SLOT_COUNT];
    logic [ias_pkg::PRIO_W-1:0]  prio_reg  [SLOT_COUNT];
    logic [AGE_BITS-1:0]         age_reg   [SLOT_COUNT];

    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [IDX_W-1:0]          best_reg, best_next;
    logic                      found_reg, found_next;
    logic [ias_pkg::SLOT_W-1:0] cur_reg;
    logic [AGE_BITS-1:0]       best_age_reg, best_age_next;
    logic [ias_pkg::PRIO_W-1:0] best_prio_reg, best_prio_next;
    logic [ias_pkg::SLOT_W-1:0] next_slot_reg;

    logic                      slot_ok, cur_ok;
    logic [IDX_W-1:0]          wr_idx, cur_idx, rd_idx;
    logic [ias_pkg::STATE_W-1:0] rd_state;
    logic [ias_pkg::PRIO_W-1:0]  rd_prio;
    logic [AGE_BITS-1:0]       rd_age;
    logic [AGE_BITS:0]         sum;
    logic [AGE_BITS-1:0]       aged;
    logic                      better;

    assign slot_ok = 32'(slot) < 32'(SLOT_COUNT);
    assign cur_ok  = 32'(cur_reg) < 32'(SLOT_COUNT);
    assign wr_idx  = IDX_W'(slot);
    assign cur_idx = IDX_W'(cur_reg);
    assign rd_idx  = cmd.finish ? cur_idx : idx_reg;

    assign rd_state = state_reg[rd_idx];
    assign rd_prio  = prio_reg[rd_idx];
    assign rd_age   = age_reg[rd_idx];

    // saturating age step
    assign sum  = {1'b0, rd_age} + (AGE_BITS+1)'(rd_prio);
    assign aged = sum[AGE_BITS] ? {AGE_BITS{1'b1}} : sum[AGE_BITS-1:0];

    assign better = !found_reg || aged > best_age_reg ||
                    (aged == best_age_reg && rd_prio > best_prio_reg);

    assign status.last = idx_reg == IDX_W'(SLOT_COUNT - 1);

    always_comb
    begin
        idx_next       = idx_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_age_next  = best_age_reg;
        best_prio_next = best_prio_reg;
        if (cmd.load)
        begin
            idx_next   = '0;
            found_next = 1'b0;
        end
        else if (cmd.scan)
        begin
            idx_next = idx_reg + IDX_W'(1);
            if (rd_state == ias_pkg::PS_READY && better)
            begin
                found_next     = 1'b1;
                best_next      = idx_reg;
                best_age_next  = aged;
                best_prio_next = rd_prio;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            found_reg <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                state_reg[i] <= ias_pkg::PS_UNUSED;
                prio_reg[i]  <= '0;
                age_reg[i]   <= '0;
            end
        end
        else
        begin
            idx_reg   <= idx_next;
            found_reg <= found_next;
            if (cmd.write && slot_ok)
            begin
                state_reg[wr_idx] <= slot_state;
                prio_reg[wr_idx]  <= slot_priority;
                if (clear_age)
                begin
                    age_reg[wr_idx] <= '0;
                end
            end
            if (cmd.scan)
            begin
                if (rd_state == ias_pkg::PS_READY)
                begin
                    age_reg[idx_reg] <= aged;
                end
                if (rd_state == ias_pkg::PS_BLOCKED)
                begin
                    state_reg[idx_reg] <= ias_pkg::PS_READY;
                end
            end
            if (cmd.finish)
            begin
                if (found_reg)
                begin
                    age_reg[best_reg] <= AGE_BITS'(best_prio_reg);
                end
                else if (cur_ok)
                begin
                    age_reg[cur_idx] <= AGE_BITS'(rd_prio);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg      <= best_next;
        best_age_reg  <= best_age_next;
        best_prio_reg <= best_prio_next;
        if (cmd.load)
        begin
            cur_reg <= current;
        end
        if (cmd.finish)
        begin
            next_slot_reg <= found_reg ? ias_pkg::SLOT_W'(best_reg) : cur_reg;
        end
    end

    assign next_slot = next_slot_reg;

endmodule
`default_nettype wire

// ===== rtl/inactive_aging_scheduler.sv =====
`default_nettype none
// channel | dir | handshake     | payload
// item    | in  | valid / ready | kind, slot, slot_state, slot_priority, clear_age, current
// result  | out | valid / ready | next_slot
//
// Write beat: table updated at the edge that accepts it.
// Schedule beat: the scan walks one slot per cycle through a single table port,
// then the finish state writes back the winner's age once the result register is free.
// Reset clears the slot table and returns the controller to idle.
// A stalled result holds its register; a schedule beat finishing behind it waits.
module inactive_aging_scheduler #(
    parameter int SLOT_COUNT = 8,
    parameter int AGE_BITS   = 16
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    ias_item_if.sink     item,
    ias_result_if.source result
);

    ias_pkg::ctrl_cmd_t  cmd;
    ias_pkg::dp_status_t status;

    ias_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_kind    (item.kind),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd),
        .status       (status)
    );

    ias_datapath #(
        .SLOT_COUNT (SLOT_COUNT),
        .AGE_BITS   (AGE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .slot          (item.slot),
        .slot_state    (item.slot_state),
        .slot_priority (item.slot_priority),
        .clear_age     (item.clear_age),
        .current       (item.current),
        .next_slot     (result.next_slot)
    );

endmodule
`default_nettype wire

// ===== rtl/ias_checker.sv =====
`default_nettype none
module ias_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       item_valid,
    input wire logic       item_ready,
    input wire logic       item_kind,
    input wire logic       result_valid,
    input wire logic       result_ready,
    input wire logic [2:0] next_slot
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result beat dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(next_slot))
        else $error("stalled result changed");

    a_sched_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_kind == ias_pkg::KIND_SCHED |=> !item_ready)
        else $error("item taken during a schedule scan");

    a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_kind == ias_pkg::KIND_WRITE |=> item_ready)
        else $error("write beat stalled the input");

endmodule

bind inactive_aging_scheduler ias_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_kind    (item.kind),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .next_slot    (result.next_slot)
);
`default_nettype wire

// ===== dv/inactive_aging_scheduler_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module inactive_aging_scheduler_tb;

    localparam int SLOTS           = 8;
    localparam int AGE_W           = 16;
    localparam int RANDOM_BEATS    = 1880;
    localparam int LONG_HOLD       = 400;
    localparam int WATCHDOG_CYCLES = 5000;
    localparam int DRAIN_CYCLES    = 4 * (SLOTS + 2);

    typedef struct {
        logic                        kind;
        logic [ias_pkg::SLOT_W-1:0]  slot;
        logic [ias_pkg::STATE_W-1:0] slot_state;
        logic [ias_pkg::PRIO_W-1:0]  slot_priority;
        logic                        clear_age;
        logic [ias_pkg::SLOT_W-1:0]  current;
    } item_beat_t;

    // Slot table shadow; one expected next_slot per schedule beat.
    class slot_table_tracker;
        logic [ias_pkg::STATE_W-1:0] slot_st [SLOTS];
        logic [ias_pkg::PRIO_W-1:0]  slot_pri [SLOTS];
        logic [AGE_W-1:0]            slot_age [SLOTS];
        logic [ias_pkg::SLOT_W-1:0]  pending_next_slots [$];
        int                          mismatches;

        function new();
            foreach (slot_st[i])
            begin
                slot_st[i]  = ias_pkg::PS_UNUSED;
                slot_pri[i] = '0;
                slot_age[i] = '0;
            end
            mismatches = 0;
        endfunction

        function void absorb_item(item_beat_t b);
            bit             was_ready [SLOTS];
            bit             found;
            int             best;
            logic [AGE_W:0] grown;

            if (b.kind == ias_pkg::KIND_WRITE)
            begin
                slot_st[b.slot]  = b.slot_state;
                slot_pri[b.slot] = b.slot_priority;
                if (b.clear_age)
                    slot_age[b.slot] = '0;
                return;
            end

            for (int i = 0; i < SLOTS; i++)
            begin
                was_ready[i] = (slot_st[i] == ias_pkg::PS_READY);
                if (was_ready[i])
                begin
                    grown       = {1'b0, slot_age[i]} + (AGE_W+1)'(slot_pri[i]);
                    slot_age[i] = grown[AGE_W] ? {AGE_W{1'b1}} : grown[AGE_W-1:0];
                end
            end

            found = 1'b0;
            best  = int'(b.current);
            for (int i = 0; i < SLOTS; i++)
            begin
                if (slot_st[i] == ias_pkg::PS_BLOCKED)
                    slot_st[i] = ias_pkg::PS_READY;
                else if (was_ready[i])
                begin
                    if (!found || slot_age[i] > slot_age[best] ||
                        (slot_age[i] == slot_age[best] && slot_pri[i] > slot_pri[best]))
                        best = i;
                    found = 1'b1;
                end
            end

            slot_age[best] = AGE_W'(slot_pri[best]);
            pending_next_slots.push_back(ias_pkg::SLOT_W'(best));
        endfunction

        function void check_next_slot(logic [ias_pkg::SLOT_W-1:0] got);
            logic [ias_pkg::SLOT_W-1:0] want;

            if (pending_next_slots.size() == 0)
            begin
                $display("%0t: unexpected next_slot beat, expected none, got %0d", $time, got);
                mismatches++;
                return;
            end
            want = pending_next_slots.pop_front();
            if (got !== want)
            begin
                $display("%0t: next_slot expected %0d, got %0d", $time, want, got);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;

    ias_item_if   item_ch ();
    ias_result_if result_ch ();

    slot_table_tracker tracker = new();
    item_beat_t        stim_q [$];

    inactive_aging_scheduler i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic void queue_write(int s, logic [ias_pkg::STATE_W-1:0] st, int p, bit clr);
        item_beat_t b;
        b.kind          = ias_pkg::KIND_WRITE;
        b.slot          = ias_pkg::SLOT_W'(s);
        b.slot_state    = st;
        b.slot_priority = ias_pkg::PRIO_W'(p);
        b.clear_age     = clr;
        b.current       = ias_pkg::SLOT_W'($urandom);
        stim_q.push_back(b);
    endfunction

    function automatic void queue_sched(int cur);
        item_beat_t b;
        b.kind          = ias_pkg::KIND_SCHED;
        b.slot          = ias_pkg::SLOT_W'($urandom);
        b.slot_state    = ias_pkg::STATE_W'($urandom);
        b.slot_priority = ias_pkg::PRIO_W'($urandom);
        b.clear_age     = 1'($urandom);
        b.current       = ias_pkg::SLOT_W'(cur);
        stim_q.push_back(b);
    endfunction

    task automatic drive_item(item_beat_t b);
        item_ch.valid         <= 1'b1;
        item_ch.kind          <= b.kind;
        item_ch.slot          <= b.slot;
        item_ch.slot_state    <= b.slot_state;
        item_ch.slot_priority <= b.slot_priority;
        item_ch.clear_age     <= b.clear_age;
        item_ch.current       <= b.current;
        do
            @(posedge clk);
        while (!item_ch.ready);
        tracker.absorb_item(b);
    endtask

    // item source
    initial
    begin
        int  gap_odds;
        int  pick;
        item_beat_t b;

        item_ch.valid         <= 1'b0;
        item_ch.kind          <= ias_pkg::KIND_WRITE;
        item_ch.slot          <= '0;
        item_ch.slot_state    <= ias_pkg::PS_UNUSED;
        item_ch.slot_priority <= '0;
        item_ch.clear_age     <= 1'b0;
        item_ch.current       <= '0;
        calm = 1'b0;

        // empty table keeps current
        queue_sched(5);
        queue_write(0, ias_pkg::PS_READY, 255, 1'b1);
        queue_write(7, ias_pkg::PS_READY, 255, 1'b1);
        queue_sched(0);
        queue_sched(0);
        queue_sched(7);
        // blocked turns ready but sits out one round; running and unused never chosen
        queue_write(3, ias_pkg::PS_BLOCKED, 200, 1'b0);
        queue_write(5, ias_pkg::PS_RUNNING, 100, 1'b1);
        queue_write(6, ias_pkg::PS_UNUSED, 50, 1'b0);
        queue_sched(3);
        queue_sched(3);
        // zero priority slots, age kept across state changes
        queue_write(1, ias_pkg::PS_READY, 0, 1'b1);
        queue_write(2, ias_pkg::PS_READY, 0, 1'b1);
        queue_write(0, ias_pkg::PS_RUNNING, 255, 1'b0);
        queue_write(7, ias_pkg::PS_RUNNING, 255, 1'b0);
        queue_write(3, ias_pkg::PS_RUNNING, 200, 1'b0);
        queue_sched(6);
        queue_write(4, ias_pkg::PS_READY, 1, 1'b1);
        queue_sched(2);
        queue_write(0, ias_pkg::PS_READY, 255, 1'b0);
        queue_write(7, ias_pkg::PS_BLOCKED, 255, 1'b1);
        queue_sched(1);
        queue_sched(4);

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            b.kind          = ($urandom_range(0, 4) < 2) ? ias_pkg::KIND_SCHED :
                                                            ias_pkg::KIND_WRITE;
            b.slot          = ias_pkg::SLOT_W'($urandom);
            pick            = $urandom_range(0, 19);
            b.slot_state    = (pick < 2) ? ias_pkg::PS_UNUSED :
                              (pick < 11) ? ias_pkg::PS_READY :
                              (pick < 14) ? ias_pkg::PS_RUNNING : ias_pkg::PS_BLOCKED;
            pick            = $urandom_range(0, 7);
            b.slot_priority = (pick == 0) ? ias_pkg::PRIO_W'(0) :
                              (pick == 1) ? ias_pkg::PRIO_W'(255) :
                              (pick < 4) ? ias_pkg::PRIO_W'($urandom_range(1, 3)) :
                                           ias_pkg::PRIO_W'($urandom);
            b.clear_age     = ($urandom_range(0, 3) == 0);
            b.current       = ias_pkg::SLOT_W'($urandom);
            stim_q.push_back(b);
        end

        wait (rst_n === 1'b1);
        @(posedge clk);

        gap_odds = 0;
        for (int n = 0; n < stim_q.size(); n++)
        begin
            if (n % 64 == 0)
                gap_odds = $urandom_range(0, 3);
            calm = (n > stim_q.size() * 7 / 8);
            drive_item(stim_q[n]);
            if (!calm && $urandom_range(0, 7) < gap_odds)
            begin
                item_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
        end
        item_ch.valid <= 1'b0;

        while (tracker.pending_next_slots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.mismatches == 0)
            $display("inactive_aging_scheduler_tb OK");
        else
            $display("inactive_aging_scheduler_tb NOT OK");
        $finish;
    end

    // result sink: random stall bursts, plus a long hold-off to back up the input
    initial
    begin
        int stall_left;
        int stall_odds;
        int stretch_left;
        int results_seen;

        stall_left   = 0;
        stall_odds   = 0;
        stretch_left = 0;
        results_seen = 0;
        result_ch.ready <= 1'b0;

        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                tracker.check_next_slot(result_ch.next_slot);
                results_seen++;
                if (results_seen % 300 == 120 && !calm)
                    stall_left = LONG_HOLD;
            end
            if (stretch_left == 0)
            begin
                stretch_left = $urandom_range(20, 80);
                stall_odds   = $urandom_range(0, 3);
            end
            stretch_left--;
            if (stall_left == 0 && !calm && $urandom_range(0, 7) < stall_odds)
                stall_left = $urandom_range(1, 5);
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= rst_n;
        end
    end

    initial
    begin
        int quiet;

        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_CYCLES)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, quiet);
                $display("inactive_aging_scheduler_tb NOT OK");
                $finish;
            end
        end
    end

endmodule
`default_nettype wire
